### src/eamt_pkg.sv
// Package for the event action match table: operation codes, field positions
// and the request/result beat structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eamt_pkg;

  // Operation codes (code 3 is unused and only acknowledged)
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Mapping word layout: key 31:12, action 11:6, data 5:0
  localparam int unsigned WordW  = 32;
  localparam int unsigned KeyW   = 20;
  localparam int unsigned KeyLsb = 12;
  localparam int unsigned ActW   = 6;
  localparam int unsigned ActLsb = 6;
  localparam int unsigned DatW   = 6;

  // Request beat
  typedef struct packed {
    logic [1:0]       operation;
    logic [WordW-1:0] entry_word;
    logic [15:0]      device_id;
    logic [1:0]       dot_field;
    logic [1:0]       td_field;
  } req_t;

  // Result beat
  typedef struct packed {
    logic            hit;
    logic [ActW-1:0] action_number;
    logic [DatW-1:0] action_data;
    logic            table_full;
    logic            last;
  } rsp_t;

endpackage

`default_nettype wire

### src/eamt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module eamt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/event_action_match_table_core.sv
// Top level of the event action match table: sequencer, entry count and the
// shared key comparator. Uses eamt_pkg and one eamt_ram for the mapping words.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+------------------------------------
//  request  | start, busy, req_i         | beat taken when start && !busy
//  result   | res_valid_o, res_o         | one-cycle strobe, cannot be stalled
//
// Clear, add and the unused code are acknowledged in the cycle after the
// beat is taken; busy never rises for them.
// A lookup holds busy while it scans the table: one RAM read is issued per
// stored entry, the single key comparator checks one registered read word per
// cycle, and each match result leaves in the cycle after the next match.
// The last result leaves as busy falls. Reset clears the count and the other
// registers of the sequencer; the mapping RAM is not cleared, entries at or
// above the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module event_action_match_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire eamt_pkg::req_t req_i,
  output logic               busy,
  output logic               res_valid_o,
  output eamt_pkg::rsp_t     res_o
);

  localparam int AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(TABLE_ENTRIES);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                          state_q, state_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic [CntW-1:0]                 idx_q, idx_d;
  logic                            rd_vld_q, rd_vld_d;
  logic [eamt_pkg::KeyW-1:0]       key_q, key_d;
  logic                            pend_vld_q, pend_vld_d;
  logic [eamt_pkg::ActW-1:0]       pend_act_q, pend_act_d;
  logic [eamt_pkg::DatW-1:0]       pend_dat_q, pend_dat_d;
  logic                            res_valid_q, res_valid_d;
  eamt_pkg::rsp_t                  res_q, res_d;

  logic                            accept;
  logic                            room;
  logic                            ram_we;
  logic                            issue;
  logic                            match;
  logic [eamt_pkg::WordW-1:0]      rd_word;

  assign accept = start && (state_q == ST_IDLE);
  assign room   = (count_q < CntMax);
  assign ram_we = accept && (req_i.operation == eamt_pkg::OP_ADD) && room;
  assign issue  = (state_q == ST_SCAN) && (idx_q != count_q);

  // Mapping word storage
  eamt_ram #(
    .WIDTH  (eamt_pkg::WordW),
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (req_i.entry_word),
    .re_i    (issue),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rd_word)
  );

  // Shared key comparator on the word read last cycle
  assign match = rd_vld_q &&
                 (rd_word[eamt_pkg::WordW-1:eamt_pkg::KeyLsb] == key_q);

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rd_vld_d    = 1'b0;
    key_d       = key_q;
    pend_vld_d  = pend_vld_q;
    pend_act_d  = pend_act_q;
    pend_dat_d  = pend_dat_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.operation)
            eamt_pkg::OP_CLEAR: begin
              count_d     = '0;
              res_valid_d = 1'b1;
            end
            eamt_pkg::OP_ADD: begin
              if (room) begin
                count_d = count_q + CntW'(1);
              end
              res_d.table_full = !room;
              res_valid_d      = 1'b1;
            end
            eamt_pkg::OP_LOOKUP: begin
              key_d      = {req_i.device_id, req_i.dot_field, req_i.td_field};
              idx_d      = '0;
              pend_vld_d = 1'b0;
              state_d    = ST_SCAN;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_d    = idx_q + CntW'(1);
          rd_vld_d = 1'b1;
        end
        if (match) begin
          // A newer match means the held one is not the last
          if (pend_vld_q) begin
            res_valid_d         = 1'b1;
            res_d.hit           = 1'b1;
            res_d.action_number = pend_act_q;
            res_d.action_data   = pend_dat_q;
            res_d.last          = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_act_d = rd_word[eamt_pkg::ActLsb +: eamt_pkg::ActW];
          pend_dat_d = rd_word[eamt_pkg::DatW-1:0];
        end else if (!issue && !rd_vld_q) begin
          // Scan done: flush the held match or report a miss
          res_valid_d = 1'b1;
          if (pend_vld_q) begin
            res_d.hit           = 1'b1;
            res_d.action_number = pend_act_q;
            res_d.action_data   = pend_dat_q;
          end
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      key_q       <= '0;
      pend_vld_q  <= 1'b0;
      pend_act_q  <= '0;
      pend_dat_q  <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      key_q       <= key_d;
      pend_vld_q  <= pend_vld_d;
      pend_act_q  <= pend_act_d;
      pend_dat_q  <= pend_dat_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count above table depth");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.hit) |->
      (res_o.action_number == '0) && (res_o.action_data == '0))
    else $error("miss result carries action fields");

  a_ack_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation != eamt_pkg::OP_LOOKUP)) |=>
      (res_valid_o && res_o.last && !busy))
    else $error("missing acknowledge beat");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SCAN))
    else $error("read data pending outside a scan");

endmodule

`default_nettype wire
